// ===== rtl/nmea_rmc_sentence_parser_assert.svh =====
// assertion macros shared by the rmc parser rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef NMEA_RMC_SENTENCE_PARSER_ASSERT_SVH
`define NMEA_RMC_SENTENCE_PARSER_ASSERT_SVH

// checked outside reset
`define NRMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NRMC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/nrmc_pkg.sv =====
// types, constants and lookup functions of the rmc sentence parser
// used by every module of the block, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package nrmc_pkg;

	localparam int FRACTION_DIGITS = 4;
	localparam int FIELD_COUNT     = 12;
	localparam int FIELD_W         = 4;
	localparam int PREFIX_LEN      = 6;
	localparam int PM_W            = 3;
	localparam int FRAC_W          = $clog2(FRACTION_DIGITS + 1);
	localparam int POW_W           = $clog2(10 ** FRACTION_DIGITS + 1);
	localparam int VAL_W           = 32;
	localparam int MAC_W           = VAL_W + 3;
	localparam int PROD_W          = VAL_W + POW_W;
	localparam int NUM_SLOTS       = 7;
	localparam int CHR_SLOTS       = 4;

	typedef logic [2:0] num_slot_t;
	typedef logic [1:0] chr_slot_t;
	typedef logic [FIELD_W-1:0] field_t;

	// numeric slots, in field order
	localparam num_slot_t SLOT_TIME   = 3'd0;
	localparam num_slot_t SLOT_LAT    = 3'd1;
	localparam num_slot_t SLOT_LON    = 3'd2;
	localparam num_slot_t SLOT_SPEED  = 3'd3;
	localparam num_slot_t SLOT_COURSE = 3'd4;
	localparam num_slot_t SLOT_DATE   = 3'd5;
	localparam num_slot_t SLOT_VAR    = 3'd6;

	// first-byte slots, in field order
	localparam chr_slot_t CSLOT_STATUS = 2'd0;
	localparam chr_slot_t CSLOT_LAT    = 2'd1;
	localparam chr_slot_t CSLOT_LON    = 2'd2;
	localparam chr_slot_t CSLOT_VAR    = 2'd3;

	// field positions after the sentence id
	localparam field_t FLD_TIME   = 4'd1;
	localparam field_t FLD_STATUS = 4'd2;
	localparam field_t FLD_LAT    = 4'd3;
	localparam field_t FLD_LATDIR = 4'd4;
	localparam field_t FLD_LON    = 4'd5;
	localparam field_t FLD_LONDIR = 4'd6;
	localparam field_t FLD_SPEED  = 4'd7;
	localparam field_t FLD_COURSE = 4'd8;
	localparam field_t FLD_DATE   = 4'd9;
	localparam field_t FLD_VAR    = 4'd10;
	localparam field_t FLD_VARDIR = 4'd11;

	localparam logic [7:0] CHAR_COMMA = 8'h2c;
	localparam logic [7:0] CHAR_POINT = 8'h2e;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// "$GPRMC"
	localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4d, 8'h43};

	localparam logic RES_PARSED       = 1'b0;
	localparam logic RES_WRONG_PREFIX = 1'b1;

	typedef struct packed {
		logic      hit;
		num_slot_t slot;
	} num_map_t;

	typedef struct packed {
		logic      hit;
		chr_slot_t slot;
	} chr_map_t;

	// one parsed beat, carrying at most one numeric close and one first-byte write
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              wrong;
		logic              close_en;
		num_slot_t         num_slot;
		logic [VAL_W-1:0]  value;
		logic [FRAC_W-1:0] frac;
		logic              char_en;
		chr_slot_t         char_slot;
		logic [7:0]        char_val;
	} parse_beat_t;

	// same beat after scaling of the closed number
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              wrong;
		logic              close_en;
		num_slot_t         num_slot;
		logic [PROD_W-1:0] product;
		logic              char_en;
		chr_slot_t         char_slot;
		logic [7:0]        char_val;
	} scaled_beat_t;

	// record fields, first output field in the lowest bits
	typedef struct packed {
		logic [7:0]  var_hemisphere;
		logic [20:0] mag_variation;
		logic [19:0] fix_date;
		logic [21:0] ground_course;
		logic [26:0] ground_speed;
		logic [7:0]  lon_hemisphere;
		logic [27:0] longitude;
		logic [7:0]  lat_hemisphere;
		logic [26:0] latitude;
		logic [7:0]  fix_status;
		logic [31:0] fix_time;
	} record_t;

	localparam int REC_W       = $bits(record_t);
	localparam int OUT_TDATA_W = ((REC_W + 7) / 8) * 8;

	function automatic num_map_t num_slot_of(field_t f);
		num_map_t m;
		m = '0;
		unique case (f)
			FLD_TIME:   m = '{hit: 1'b1, slot: SLOT_TIME};
			FLD_LAT:    m = '{hit: 1'b1, slot: SLOT_LAT};
			FLD_LON:    m = '{hit: 1'b1, slot: SLOT_LON};
			FLD_SPEED:  m = '{hit: 1'b1, slot: SLOT_SPEED};
			FLD_COURSE: m = '{hit: 1'b1, slot: SLOT_COURSE};
			FLD_DATE:   m = '{hit: 1'b1, slot: SLOT_DATE};
			FLD_VAR:    m = '{hit: 1'b1, slot: SLOT_VAR};
			default:    m = '0;
		endcase
		return m;
	endfunction

	function automatic chr_map_t chr_slot_of(field_t f);
		chr_map_t m;
		m = '0;
		unique case (f)
			FLD_STATUS: m = '{hit: 1'b1, slot: CSLOT_STATUS};
			FLD_LATDIR: m = '{hit: 1'b1, slot: CSLOT_LAT};
			FLD_LONDIR: m = '{hit: 1'b1, slot: CSLOT_LON};
			FLD_VARDIR: m = '{hit: 1'b1, slot: CSLOT_VAR};
			default:    m = '0;
		endcase
		return m;
	endfunction

	// saturation limit of each numeric slot
	function automatic logic [VAL_W-1:0] num_max(num_slot_t s);
		logic [VAL_W-1:0] m;
		m = '0;
		unique case (s)
			SLOT_TIME:   m = 32'd2359599999;
			SLOT_LAT:    m = 32'd90000000;
			SLOT_LON:    m = 32'd180000000;
			SLOT_SPEED:  m = 32'd99999999;
			SLOT_COURSE: m = 32'd3600000;
			SLOT_DATE:   m = 32'd999999;
			SLOT_VAR:    m = 32'd1800000;
			default:     m = '0;
		endcase
		return m;
	endfunction

	// 10^k for k up to the fraction digit count
	function automatic logic [POW_W-1:0] pow10(logic [FRAC_W-1:0] k);
		logic [POW_W-1:0] p;
		p = POW_W'(1);
		for (int i = 0; i < FRACTION_DIGITS; i++) begin
			if (i < int'(k)) begin
				p = POW_W'(p * 10);
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/nrmc_byte_parse.sv =====
// per-byte parser: prefix check, field split, digit accumulation
// depends on nrmc_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_rmc_sentence_parser_assert.svh"

module nrmc_byte_parse (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  in_valid,
	input  wire [7:0]            in_byte,
	input  wire                  in_last,
	output nrmc_pkg::parse_beat_t beat_s2
);
	import nrmc_pkg::*;

	logic [PM_W-1:0]   pm_q,   pm_d;
	logic              pw_q,   pw_d;
	field_t            fld_q,  fld_d;
	logic [VAL_W-1:0]  rv_q,   rv_d;
	logic [FRAC_W-1:0] frac_q, frac_d;
	logic              ap_q,   ap_d;
	logic              ne_q,   ne_d;
	logic              fe_q,   fe_d;
	parse_beat_t       beat_d;

	num_map_t          nmap;
	chr_map_t          cmap;
	logic              active;
	logic              is_digit;
	logic [7:0]        diff;
	logic [MAC_W-1:0]  mac;
	logic [VAL_W-1:0]  lim;

	// next state and the beat handed to the scaling stage
	always_comb begin
		pm_d   = pm_q;
		pw_d   = pw_q;
		fld_d  = fld_q;
		rv_d   = rv_q;
		frac_d = frac_q;
		ap_d   = ap_q;
		ne_d   = ne_q;
		fe_d   = fe_q;
		beat_d = '0;
		beat_d.valid = 1'b1;
		beat_d.last  = in_last;

		nmap     = num_slot_of(fld_q);
		cmap     = chr_slot_of(fld_q);
		active   = fld_q < FIELD_W'(FIELD_COUNT);
		is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
		diff     = in_byte - CHAR_ZERO;
		lim      = num_max(nmap.slot);
		mac      = ({3'b000, rv_q} << 3) + ({3'b000, rv_q} << 1) + MAC_W'(diff[3:0]);

		// prefix match
		if (!pw_q && pm_q < PM_W'(PREFIX_LEN)) begin
			if (in_byte == PREFIX_TEXT[pm_q]) begin
				pm_d = pm_q + PM_W'(1);
			end else begin
				pw_d = 1'b1;
			end
		end

		if (active) begin
			if (in_byte == CHAR_COMMA) begin
				// close the field with the value so far and open the next
				beat_d.close_en = nmap.hit;
				beat_d.num_slot = nmap.slot;
				beat_d.value    = rv_q;
				beat_d.frac     = frac_q;
				fld_d  = fld_q + FIELD_W'(1);
				rv_d   = '0;
				frac_d = '0;
				ap_d   = 1'b0;
				ne_d   = 1'b0;
				fe_d   = 1'b1;
			end else begin
				// first byte of a character field
				if (cmap.hit && fe_q) begin
					beat_d.char_en   = 1'b1;
					beat_d.char_slot = cmap.slot;
					beat_d.char_val  = in_byte;
				end
				// number accumulation
				if (nmap.hit && !ne_q) begin
					if (is_digit) begin
						if (!ap_q || frac_q < FRAC_W'(FRACTION_DIGITS)) begin
							if (ap_q) begin
								frac_d = frac_q + FRAC_W'(1);
							end
							rv_d = (mac > MAC_W'(lim)) ? lim : mac[VAL_W-1:0];
						end
					end else if (in_byte == CHAR_POINT && !ap_q && nmap.slot != SLOT_DATE) begin
						ap_d = 1'b1;
					end else begin
						ne_d = 1'b1;
					end
				end
				fe_d = 1'b0;
				// the last byte closes the open field
				if (in_last) begin
					beat_d.close_en = nmap.hit;
					beat_d.num_slot = nmap.slot;
					beat_d.value    = rv_d;
					beat_d.frac     = frac_d;
				end
			end
		end

		beat_d.wrong = pw_d || (pm_d < PM_W'(PREFIX_LEN));

		// back to reset state after the last byte
		if (in_last) begin
			pm_d   = '0;
			pw_d   = 1'b0;
			fld_d  = '0;
			rv_d   = '0;
			frac_d = '0;
			ap_d   = 1'b0;
			ne_d   = 1'b0;
			fe_d   = 1'b1;
		end

		if (!in_valid) begin
			beat_d = '0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q   <= '0;
			pw_q   <= 1'b0;
			fld_q  <= '0;
			rv_q   <= '0;
			frac_q <= '0;
			ap_q   <= 1'b0;
			ne_q   <= 1'b0;
			fe_q   <= 1'b1;
		end else if (en && in_valid) begin
			pm_q   <= pm_d;
			pw_q   <= pw_d;
			fld_q  <= fld_d;
			rv_q   <= rv_d;
			frac_q <= frac_d;
			ap_q   <= ap_d;
			ne_q   <= ne_d;
			fe_q   <= fe_d;
		end
	end

	// stage register toward scaling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s2 <= '0;
		end else if (en) begin
			beat_s2 <= beat_d;
		end
	end

	`NRMC_ASSERT(a_field_bound, fld_q <= FIELD_W'(FIELD_COUNT), "field number past its limit")
	`NRMC_ASSERT(a_last_clears, en && in_valid && in_last |=> (fld_q == '0 && rv_q == '0 && fe_q), "parser state not cleared after last beat")

endmodule

`default_nettype wire

// ===== rtl/nrmc_scale.sv =====
// scales a closed number by the missing power of ten
// depends on nrmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nrmc_scale (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  nrmc_pkg::parse_beat_t  beat_s2,
	output nrmc_pkg::scaled_beat_t beat_s3
);
	import nrmc_pkg::*;

	logic [FRAC_W-1:0] k;
	scaled_beat_t      beat_d;

	// fraction digits not given are filled with zeros; the date takes none
	always_comb begin
		k = (beat_s2.num_slot == SLOT_DATE) ? '0 : FRAC_W'(FRACTION_DIGITS) - beat_s2.frac;
		beat_d.valid     = beat_s2.valid;
		beat_d.last      = beat_s2.last;
		beat_d.wrong     = beat_s2.wrong;
		beat_d.close_en  = beat_s2.close_en;
		beat_d.num_slot  = beat_s2.num_slot;
		beat_d.product   = PROD_W'(beat_s2.value) * PROD_W'(pow10(k));
		beat_d.char_en   = beat_s2.char_en;
		beat_d.char_slot = beat_s2.char_slot;
		beat_d.char_val  = beat_s2.char_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s3 <= '0;
		end else if (en) begin
			beat_s3 <= beat_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/nrmc_record.sv =====
// saturation, saved field store and the output record register
// depends on nrmc_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_rmc_sentence_parser_assert.svh"

module nrmc_record (
	input  wire                    clk,
	input  wire                    arst_n,
	input  nrmc_pkg::scaled_beat_t beat_s3,
	input  wire                    out_ready,
	output logic                   stall,
	output logic                   out_valid,
	output logic                   out_code,
	output nrmc_pkg::record_t      out_rec
);
	import nrmc_pkg::*;

	logic [VAL_W-1:0] saved_num_q [NUM_SLOTS];
	logic [7:0]       saved_chr_q [CHR_SLOTS];
	logic [VAL_W-1:0] num_n [NUM_SLOTS];
	logic [7:0]       chr_n [CHR_SLOTS];
	logic [VAL_W-1:0] lim;
	logic [VAL_W-1:0] sat;
	logic             emit;
	logic             load;
	logic             out_valid_q;
	logic             code_q;
	record_t          rec_q;
	record_t          rec_d;

	// saturate and merge this beat's writes into the store
	always_comb begin
		lim = num_max(beat_s3.num_slot);
		sat = (beat_s3.product > PROD_W'(lim)) ? lim : beat_s3.product[VAL_W-1:0];
		for (int i = 0; i < NUM_SLOTS; i++) begin
			num_n[i] = saved_num_q[i];
		end
		for (int i = 0; i < CHR_SLOTS; i++) begin
			chr_n[i] = saved_chr_q[i];
		end
		if (beat_s3.valid && beat_s3.close_en) begin
			num_n[beat_s3.num_slot] = sat;
		end
		if (beat_s3.valid && beat_s3.char_en) begin
			chr_n[beat_s3.char_slot] = beat_s3.char_val;
		end
	end

	// record assembly
	always_comb begin
		rec_d.fix_time       = num_n[SLOT_TIME];
		rec_d.fix_status     = chr_n[CSLOT_STATUS];
		rec_d.latitude       = num_n[SLOT_LAT][26:0];
		rec_d.lat_hemisphere = chr_n[CSLOT_LAT];
		rec_d.longitude      = num_n[SLOT_LON][27:0];
		rec_d.lon_hemisphere = chr_n[CSLOT_LON];
		rec_d.ground_speed   = num_n[SLOT_SPEED][26:0];
		rec_d.ground_course  = num_n[SLOT_COURSE][21:0];
		rec_d.fix_date       = num_n[SLOT_DATE][19:0];
		rec_d.mag_variation  = num_n[SLOT_VAR][20:0];
		rec_d.var_hemisphere = chr_n[CSLOT_VAR];
		if (beat_s3.wrong) begin
			rec_d = '0;
		end
	end

	// hold the pipeline only when a record meets a full, stalled output
	assign emit  = beat_s3.valid && beat_s3.last;
	assign stall = emit && out_valid_q && !out_ready;
	assign load  = emit && !stall;

	// saved fields, cleared once the record is loaded into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				saved_num_q[i] <= '0;
			end
			for (int i = 0; i < CHR_SLOTS; i++) begin
				saved_chr_q[i] <= '0;
			end
		end else if (!stall && beat_s3.valid) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				saved_num_q[i] <= emit ? '0 : num_n[i];
			end
			for (int i = 0; i < CHR_SLOTS; i++) begin
				saved_chr_q[i] <= emit ? '0 : chr_n[i];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q  <= rec_d;
			code_q <= beat_s3.wrong ? RES_WRONG_PREFIX : RES_PARSED;
		end
	end

	assign out_valid = out_valid_q;
	assign out_code  = code_q;
	assign out_rec   = rec_q;

	`NRMC_ASSERT(a_wrong_zero, out_valid_q && code_q == RES_WRONG_PREFIX |-> (rec_q == '0), "wrong prefix record carries data")
	`NRMC_ASSERT(a_stall_src, stall |-> (beat_s3.last && out_valid_q && !out_ready), "stall without a blocked record")
	`NRMC_ASSERT(a_clear_after, load |=> (saved_num_q[SLOT_TIME] == '0 && saved_chr_q[CSLOT_STATUS] == '0), "saved fields kept after record")
	`NRMC_ASSERT_RST(a_rst_idle, !arst_n |-> !out_valid_q, "record valid during reset")

endmodule

`default_nettype wire

// ===== rtl/nmea_rmc_sentence_parser.sv =====
// GPRMC sentence parser, top level: input register and stream ports
// depends on nrmc_pkg, nrmc_byte_parse, nrmc_scale and nrmc_record
//
// Input stream s_*: one sentence byte per beat in s_tdata, s_tlast on the
// final byte of a sentence. Output stream m_*: one record per sentence,
// sent after its final byte; m_tuser carries the result code (1 when the
// sentence does not open with $GPRMC, and then all of m_tdata is zero).
// Throughput: one byte per cycle while s_tready is high. The path is
// an input register, the parse stage (prefix, field split, multiply-by-ten
// accumulation), the scale stage (one multiply by a power of ten) and the
// saturation and record register, which loads the record and raises
// m_tvalid when the final byte of its sentence has gone through them.
// Stalls: bytes keep flowing while a record waits in the output register;
// s_tready drops only when a second record reaches the output stage while
// the first is still held by m_tready low.
// Reset: arst_n clears the parser, the saved fields and both valids; the
// block takes bytes in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module nmea_rmc_sentence_parser (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [7:0]                          s_tdata,   // [7:0] char_byte
	input  wire                                 s_tlast,   // last_byte
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [nrmc_pkg::OUT_TDATA_W-1:0]    m_tdata,   // fix_time, fix_status,
	                                                       // latitude, lat_hemisphere,
	                                                       // longitude, lon_hemisphere,
	                                                       // ground_speed, ground_course,
	                                                       // fix_date, mag_variation,
	                                                       // var_hemisphere, zero pad
	output logic [0:0]                          m_tuser    // [0] result_code
);
	import nrmc_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         stall;
	parse_beat_t  beat_s2;
	scaled_beat_t beat_s3;
	logic         rec_code;
	record_t      rec;

	assign s_tready = !stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	nrmc_byte_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (!stall),
		.in_valid (valid_s1),
		.in_byte  (byte_s1),
		.in_last  (last_s1),
		.beat_s2  (beat_s2)
	);

	nrmc_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (!stall),
		.beat_s2 (beat_s2),
		.beat_s3 (beat_s3)
	);

	nrmc_record u_record (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_s3   (beat_s3),
		.out_ready (m_tready),
		.stall     (stall),
		.out_valid (m_tvalid),
		.out_code  (rec_code),
		.out_rec   (rec)
	);

	// pack the record, first field in the lowest bits
	assign m_tdata    = OUT_TDATA_W'(rec);
	assign m_tuser[0] = rec_code;

endmodule

`default_nettype wire
